/* src/rwdf_pkg.sv */
// Package for the recent-window duplicate filter.
// Holds fixed field widths, reset values and the controller command struct.
// No dependencies.
package rwdf_pkg;

    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int WL_W = 5;
    localparam logic [WL_W-1:0] WL_RESET = WL_W'(1);

    // Largest window a WL_W-bit length register can ask for.
    localparam int WL_LIMIT = (1 << WL_W) - 1;

    typedef struct packed {
        logic load;
        logic cfg_write;
    } rwdf_cmd_t;

endpackage

/* src/rwdf_if.sv */
// Channel interfaces of the recent-window duplicate filter.
// Depends on rwdf_pkg for the fixed field widths.
interface rwdf_item_if #(
    parameter int TYPE_BITS = 20
);
    logic                 valid;
    logic                 ready;
    logic [TYPE_BITS-1:0] item_type;
    logic                 start_of_run;

    modport source (output valid, item_type, start_of_run, input ready);
    modport sink   (input valid, item_type, start_of_run, output ready);
endinterface

interface rwdf_result_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [rwdf_pkg::COUNT_W-1:0] accepted_count;

    modport source (output valid, accepted, accepted_count, input ready);
    modport sink   (input valid, accepted, accepted_count, output ready);
endinterface

interface rwdf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rwdf_pkg::WL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/rwdf_ctrl.sv */
// Controller of the recent-window duplicate filter: tracks the output register
// and issues load and configuration commands. Depends on rwdf_pkg.
module rwdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output rwdf_pkg::rwdf_cmd_t cmd
);
    import rwdf_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;

    // The output register can take a new beat when empty or when its beat leaves now.
    assign in_ready      = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid     = (state_reg == ST_FULL);
    assign cfg_ready     = 1'b1;
    assign cmd.load      = in_valid && in_ready;
    assign cmd.cfg_write = cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.load)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (cmd.load)
                    state_next = ST_FULL;
                else if (out_ready)
                    state_next = ST_EMPTY;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

/* src/rwdf_datapath.sv */
// Datapath of the recent-window duplicate filter: window shift register,
// parallel compare, saturating counter and result register. Depends on rwdf_pkg.
module rwdf_datapath #(
    parameter int MAX_WINDOW = 16,
    parameter int TYPE_BITS  = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rwdf_pkg::rwdf_cmd_t           cmd,
    input  logic [rwdf_pkg::WL_W-1:0]     cfg_data,
    input  logic [TYPE_BITS-1:0]          item_type,
    input  logic                          start_of_run,
    output logic                          accepted,
    output logic [rwdf_pkg::COUNT_W-1:0]  accepted_count
);
    import rwdf_pkg::*;

    // Entries past the longest window the length register can select are never
    // compared, so they are not stored.
    localparam int DEPTH = (MAX_WINDOW < WL_LIMIT) ? MAX_WINDOW : WL_LIMIT;

    logic [WL_W-1:0]      wl_reg;
    logic [TYPE_BITS-1:0] types_reg [DEPTH];
    logic [TYPE_BITS-1:0] types_next [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [DEPTH-1:0]     valid_next;
    logic [DEPTH-1:0]     live;
    logic [DEPTH-1:0]     match;
    logic                 hit;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_base;
    logic [COUNT_W-1:0]   count_next;
    logic                 accepted_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    // A start clears the window before the compare, so nothing can match.
    assign live = start_of_run ? '0 : valid_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = live[i] && (types_reg[i] == item_type)
                       && ((i == 0) || (32'(wl_reg) > i));
        end
    end

    assign hit = |match;
    assign count_base = start_of_run ? '0 : count_reg;

    always_comb
    begin
        valid_next = live;
        count_next = count_base;
        for (int i = 0; i < DEPTH; i++)
            types_next[i] = types_reg[i];
        if (!hit)
        begin
            types_next[0] = item_type;
            valid_next[0] = 1'b1;
            for (int i = 1; i < DEPTH; i++)
            begin
                types_next[i] = types_reg[i-1];
                valid_next[i] = live[i-1];
            end
            if (count_base != COUNT_MAX)
                count_next = count_base + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= WL_RESET;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
                wl_reg <= cfg_data;
            if (cmd.load)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < DEPTH; i++)
                types_reg[i] <= types_next[i];
            accepted_reg  <= !hit;
            out_count_reg <= count_next;
        end
    end

    assign accepted       = accepted_reg;
    assign accepted_count = out_count_reg;

endmodule

/* src/recent_window_duplicate_filter_unit.sv */
// Recent-window duplicate filter, top level. Depends on rwdf_pkg, rwdf_if,
// rwdf_ctrl and rwdf_datapath.
// Latency: a result is valid the cycle after its item's beat is taken.
// Throughput: one item per cycle while results are taken; the whole window is
// compared in parallel against the window registers.
// Reset: window empty, count zero, window length 1, no result pending.
module recent_window_duplicate_filter_unit #(
    parameter int MAX_WINDOW = 16,
    parameter int TYPE_BITS  = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    rwdf_cfg_if.sink      cfg,
    rwdf_item_if.sink     items,
    rwdf_result_if.source results
);
    import rwdf_pkg::*;

    rwdf_cmd_t cmd;

    rwdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cmd       (cmd)
    );

    rwdf_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .TYPE_BITS  (TYPE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_data       (cfg.data),
        .item_type      (items.item_type),
        .start_of_run   (items.start_of_run),
        .accepted       (results.accepted),
        .accepted_count (results.accepted_count)
    );

endmodule

/* src/rwdf_checker.sv */
// Port-level checker for the recent-window duplicate filter, bound to the top
// level. Depends on rwdf_pkg.
module rwdf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         start_of_run,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         accepted,
    input logic [rwdf_pkg::COUNT_W-1:0] accepted_count
);
    import rwdf_pkg::*;

    // Every input beat yields a result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after an input beat");

    // The first item of a run is always accepted and counted as one.
    a_start_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && start_of_run)
        |=> (accepted && (accepted_count == COUNT_W'(1))))
        else $error("start of run did not restart the count");

    // A rejection means the window held a type, so something was counted.
    a_reject_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (accepted_count != '0))
        else $error("rejected item with an empty count");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
        |=> (out_valid && $stable(accepted) && $stable(accepted_count)))
        else $error("stalled result changed");

endmodule

bind recent_window_duplicate_filter_unit rwdf_checker u_rwdf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .start_of_run   (items.start_of_run),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .accepted       (results.accepted),
    .accepted_count (results.accepted_count)
);
